/* rtl/core/gmss_pkg.sv */
// gmss_pkg: types, codes and sizes shared by the grid search step unit.
// No dependencies; gmss_ctrl, gmss_dp and the top level refer to it by scoped names.
package gmss_pkg;

    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int CODE_W     = 3;
    localparam int STAT_W     = 3;
    localparam int REQ_W      = 2;
    localparam int GRID_W     = 7;
    localparam int CELL_AW    = ROW_W + COL_W;
    localparam int CELL_DEPTH = 1 << CELL_AW;
    localparam int NODE_DEPTH = 4096;
    localparam int NODE_AW    = $clog2(NODE_DEPTH);
    localparam int CNT_W      = NODE_AW + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [GRID_W-1:0] MAX_ROWS = GRID_W'(1 << ROW_W);
    localparam logic [GRID_W-1:0] MAX_COLS = GRID_W'(1 << COL_W);

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd3;

    // cell codes
    localparam logic [CODE_W-1:0] CELL_WALL    = 3'd0;
    localparam logic [CODE_W-1:0] CELL_OPEN    = 3'd1;
    localparam logic [CODE_W-1:0] CELL_END     = 3'd2;
    localparam logic [CODE_W-1:0] CELL_VISITED = 3'd4;
    localparam logic [CODE_W-1:0] CELL_PATH    = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXPANDED = 3'd1;
    localparam logic [STAT_W-1:0] ST_SKIPPED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_SOLVED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_FIRST = 3'd4;

    // neighbor directions in visiting order
    localparam logic [1:0] DIR_WEST  = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_EAST  = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CODE_W-1:0] cell_code;
    } t_in_beat;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic [CODE_W-1:0] read_code;
    } t_out_beat;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               has_par;
        logic [NODE_AW-1:0] par;
    } t_node;

    typedef enum logic [3:0] {
        S_BOOT_CLEAR, S_IDLE, S_WRITE, S_READ, S_READ_WAIT, S_CLEAR, S_SEED,
        S_POP, S_NODE_RD, S_HERE_RD, S_DECIDE, S_BT_CHK, S_EXPAND, S_NB_RD,
        S_NB_CHK, S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LATCH, CMD_CLR, CMD_SEED, CMD_WRITE, CMD_READ, CMD_READ_DONE,
        CMD_EMPTY, CMD_POP, CMD_NODE_RD, CMD_HERE_RD, CMD_DECIDE, CMD_BT_STEP,
        CMD_EXPAND, CMD_NB_RD, CMD_NB_NEXT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              nb_chk;
        logic              load;
        logic              set_st;
        logic [STAT_W-1:0] st;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             fr_empty;
        logic             here_end;
        logic             here_vis;
        logic             has_par;
        logic             bt_go;
        logic             nb_inb;
        logic             dir_last;
        logic             clr_last;
        logic             over;
        logic             out_free;
    } t_status;

endpackage

/* rtl/core/grid_maze_search_step_unit.sv */
// grid_maze_search_step_unit: grid path search engine (BFS/DFS) with cell access.
// Requests: write, read, restart (visited clear, then root seed) and step; a step
// reports empty on an empty frontier, skipped on a visited cell, solved after
// marking the path cells, or expanded or overflow after checking each in-bounds neighbor.
// One request at a time; a held result stalls it.
// Synchronous active-low reset; a clear of the whole visited RAM follows, stall held high.
module grid_maze_search_step_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gmss_pkg::t_in_beat              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gmss_pkg::t_out_beat             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [gmss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gmss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    gmss_pkg::t_cmd    cmd;
    gmss_pkg::t_status stat;
    logic              idle;

    gmss_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_stat(stat), .o_cmd(cmd), .o_idle(idle)
    );

    gmss_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_in_data(i_in_data), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    assign o_in_stall = !idle;

endmodule

/* rtl/core/gmss_ram.sv */
// gmss_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module gmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/gmss_ctrl.sv */
// gmss_ctrl: sequencer of the grid search step unit.
// Depends on gmss_pkg; drives one command per cycle into gmss_dp.
module gmss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  gmss_pkg::t_status i_stat,
    output gmss_pkg::t_cmd   o_cmd,
    output logic             o_idle
);

    gmss_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmss_pkg::S_BOOT_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gmss_pkg::S_BOOT_CLEAR: if (i_stat.clr_last) n_state = gmss_pkg::S_IDLE;
            gmss_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_stat.req)
                        gmss_pkg::REQ_WRITE: n_state = gmss_pkg::S_WRITE;
                        gmss_pkg::REQ_READ:  n_state = gmss_pkg::S_READ;
                        gmss_pkg::REQ_STEP:  n_state = gmss_pkg::S_POP;
                        default:             n_state = gmss_pkg::S_CLEAR;
                    endcase
                end
            end
            gmss_pkg::S_WRITE:     n_state = gmss_pkg::S_FINISH;
            gmss_pkg::S_READ:      n_state = gmss_pkg::S_READ_WAIT;
            gmss_pkg::S_READ_WAIT: n_state = gmss_pkg::S_FINISH;
            gmss_pkg::S_CLEAR:     if (i_stat.clr_last) n_state = gmss_pkg::S_SEED;
            gmss_pkg::S_SEED:      n_state = gmss_pkg::S_FINISH;
            gmss_pkg::S_POP: begin
                n_state = i_stat.fr_empty ? gmss_pkg::S_FINISH : gmss_pkg::S_NODE_RD;
            end
            gmss_pkg::S_NODE_RD:   n_state = gmss_pkg::S_HERE_RD;
            gmss_pkg::S_HERE_RD:   n_state = gmss_pkg::S_DECIDE;
            gmss_pkg::S_DECIDE: begin
                priority if (i_stat.here_end) begin
                    n_state = i_stat.has_par ? gmss_pkg::S_BT_CHK : gmss_pkg::S_FINISH;
                end else if (i_stat.here_vis) begin
                    n_state = gmss_pkg::S_FINISH;
                end else begin
                    n_state = gmss_pkg::S_EXPAND;
                end
            end
            gmss_pkg::S_BT_CHK:    if (!i_stat.bt_go) n_state = gmss_pkg::S_FINISH;
            gmss_pkg::S_EXPAND:    n_state = gmss_pkg::S_NB_RD;
            gmss_pkg::S_NB_RD: begin
                priority if (i_stat.nb_inb)   n_state = gmss_pkg::S_NB_CHK;
                else if (i_stat.dir_last)     n_state = gmss_pkg::S_FINISH;
            end
            gmss_pkg::S_NB_CHK: begin
                n_state = i_stat.dir_last ? gmss_pkg::S_FINISH : gmss_pkg::S_NB_RD;
            end
            gmss_pkg::S_FINISH:    if (i_stat.out_free) n_state = gmss_pkg::S_IDLE;
            default:               n_state = gmss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = gmss_pkg::CMD_NONE;
        o_idle       = 1'b0;
        unique case (r_state)
            gmss_pkg::S_BOOT_CLEAR: o_cmd.op = gmss_pkg::CMD_CLR;
            gmss_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_in_valid) o_cmd.op = gmss_pkg::CMD_LATCH;
            end
            gmss_pkg::S_WRITE: begin
                o_cmd.op     = gmss_pkg::CMD_WRITE;
                o_cmd.set_st = 1'b1;
                o_cmd.st     = gmss_pkg::ST_DONE;
            end
            gmss_pkg::S_READ:      o_cmd.op = gmss_pkg::CMD_READ;
            gmss_pkg::S_READ_WAIT: begin
                o_cmd.op     = gmss_pkg::CMD_READ_DONE;
                o_cmd.set_st = 1'b1;
                o_cmd.st     = gmss_pkg::ST_DONE;
            end
            gmss_pkg::S_CLEAR:     o_cmd.op = gmss_pkg::CMD_CLR;
            gmss_pkg::S_SEED: begin
                o_cmd.op     = gmss_pkg::CMD_SEED;
                o_cmd.set_st = 1'b1;
                o_cmd.st     = gmss_pkg::ST_DONE;
            end
            gmss_pkg::S_POP: begin
                if (i_stat.fr_empty) begin
                    o_cmd.op     = gmss_pkg::CMD_EMPTY;
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = gmss_pkg::ST_EMPTY;
                end else begin
                    o_cmd.op = gmss_pkg::CMD_POP;
                end
            end
            gmss_pkg::S_NODE_RD:   o_cmd.op = gmss_pkg::CMD_NODE_RD;
            gmss_pkg::S_HERE_RD:   o_cmd.op = gmss_pkg::CMD_HERE_RD;
            gmss_pkg::S_DECIDE: begin
                o_cmd.op = gmss_pkg::CMD_DECIDE;
                priority if (i_stat.here_end) begin
                    o_cmd.set_st = !i_stat.has_par;
                    o_cmd.st     = gmss_pkg::ST_SOLVED;
                end else if (i_stat.here_vis) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = gmss_pkg::ST_SKIPPED;
                end
            end
            gmss_pkg::S_BT_CHK: begin
                if (i_stat.bt_go) begin
                    o_cmd.op = gmss_pkg::CMD_BT_STEP;
                end else begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = gmss_pkg::ST_SOLVED;
                end
            end
            gmss_pkg::S_EXPAND:    o_cmd.op = gmss_pkg::CMD_EXPAND;
            gmss_pkg::S_NB_RD: begin
                priority if (i_stat.nb_inb) begin
                    o_cmd.op = gmss_pkg::CMD_NB_RD;
                end else if (i_stat.dir_last) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = i_stat.over ? gmss_pkg::ST_OVERFLOW : gmss_pkg::ST_EXPANDED;
                end else begin
                    o_cmd.op = gmss_pkg::CMD_NB_NEXT;
                end
            end
            gmss_pkg::S_NB_CHK: begin
                // status takes this cycle's overflow inside the datapath
                o_cmd.op     = gmss_pkg::CMD_NB_NEXT;
                o_cmd.nb_chk = 1'b1;
                o_cmd.set_st = i_stat.dir_last;
                o_cmd.st     = gmss_pkg::ST_EXPANDED;
            end
            gmss_pkg::S_FINISH:    o_cmd.load = i_stat.out_free;
            default:               o_cmd.op = gmss_pkg::CMD_NONE;
        endcase
    end

endmodule

/* rtl/core/gmss_dp.sv */
// gmss_dp: datapath of the grid search step unit: cell, visited, node and
// frontier RAMs, search counters, config registers and the result register.
// Depends on gmss_pkg and gmss_ram.
module gmss_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gmss_pkg::t_cmd                i_cmd,
    output gmss_pkg::t_status             o_stat,
    input  gmss_pkg::t_in_beat            i_in_data,
    input  logic                          i_cfg_we,
    input  logic [gmss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gmss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gmss_pkg::t_out_beat           o_out_data
);

    localparam logic [gmss_pkg::CNT_W-1:0] DEPTH_C = gmss_pkg::CNT_W'(gmss_pkg::NODE_DEPTH);

    // config
    logic [gmss_pkg::GRID_W-1:0] r_num_rows, r_num_cols;
    logic [gmss_pkg::ROW_W-1:0]  r_start_row;
    logic [gmss_pkg::COL_W-1:0]  r_start_col;
    logic                        r_depth_first;

    // search state
    logic [gmss_pkg::CELL_AW-1:0] r_clr;
    logic [gmss_pkg::NODE_AW-1:0] r_head;
    logic [gmss_pkg::CNT_W-1:0]   r_cnt, r_nc, r_guard;
    logic [gmss_pkg::NODE_AW-1:0] r_node, r_par;
    logic                         r_has_par;
    logic [gmss_pkg::ROW_W-1:0]   r_r, r_req_row;
    logic [gmss_pkg::COL_W-1:0]   r_c, r_req_col;
    logic [gmss_pkg::CODE_W-1:0]  r_here, r_req_code;
    logic [1:0]                   r_dir;
    logic                         r_over;
    gmss_pkg::t_out_beat          r_res, r_out;
    logic                         r_out_valid;

    // RAM ports
    logic                          cell_we, vis_we, vis_wdata, vis_rdata, node_we, fr_we;
    logic [gmss_pkg::CELL_AW-1:0]  cell_waddr, cell_raddr, vis_waddr, vis_raddr;
    logic [gmss_pkg::CODE_W-1:0]   cell_wdata, cell_rdata;
    logic [gmss_pkg::NODE_AW-1:0]  node_waddr, node_raddr, fr_waddr, fr_raddr;
    logic [gmss_pkg::NODE_AW-1:0]  fr_wdata, fr_rdata;
    gmss_pkg::t_node               node_wdata, node_rdata;

    // neighbor
    logic [gmss_pkg::GRID_W-1:0] er, ec, nr7, nc7;
    logic                        nb_ok, nb_inb, nb_take, full;
    logic [gmss_pkg::CELL_AW-1:0] nb_addr;
    logic [gmss_pkg::NODE_AW-1:0] pop_pos, push_pos;

    assign er = (r_num_rows > gmss_pkg::MAX_ROWS) ? gmss_pkg::MAX_ROWS : r_num_rows;
    assign ec = (r_num_cols > gmss_pkg::MAX_COLS) ? gmss_pkg::MAX_COLS : r_num_cols;

    always_comb begin
        nr7   = {1'b0, r_r};
        nc7   = {1'b0, r_c};
        nb_ok = 1'b1;
        unique case (r_dir)
            gmss_pkg::DIR_WEST: begin
                nb_ok = (r_c != '0);
                nc7   = {1'b0, r_c} - gmss_pkg::GRID_W'(1);
            end
            gmss_pkg::DIR_SOUTH: nr7 = {1'b0, r_r} + gmss_pkg::GRID_W'(1);
            gmss_pkg::DIR_EAST:  nc7 = {1'b0, r_c} + gmss_pkg::GRID_W'(1);
            default: begin
                nb_ok = (r_r != '0);
                nr7   = {1'b0, r_r} - gmss_pkg::GRID_W'(1);
            end
        endcase
    end

    assign nb_inb  = nb_ok && (nr7 < er) && (nc7 < ec);
    assign nb_addr = {nr7[gmss_pkg::ROW_W-1:0], nc7[gmss_pkg::COL_W-1:0]};
    assign nb_take = ((cell_rdata == gmss_pkg::CELL_OPEN) || (cell_rdata == gmss_pkg::CELL_END))
                     && !vis_rdata;
    assign full    = (r_nc >= DEPTH_C) || (r_cnt >= DEPTH_C);
    assign push_pos = r_head + r_cnt[gmss_pkg::NODE_AW-1:0];
    assign pop_pos  = r_depth_first ? (r_head + r_cnt[gmss_pkg::NODE_AW-1:0]
                                       - gmss_pkg::NODE_AW'(1)) : r_head;

    // RAM command decode
    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = {r_req_row, r_req_col};
        cell_wdata = r_req_code;
        cell_raddr = {r_req_row, r_req_col};
        vis_we     = 1'b0;
        vis_waddr  = r_clr;
        vis_wdata  = 1'b0;
        vis_raddr  = nb_addr;
        node_we    = 1'b0;
        node_waddr = r_nc[gmss_pkg::NODE_AW-1:0];
        node_wdata = '{row: nr7[gmss_pkg::ROW_W-1:0], col: nc7[gmss_pkg::COL_W-1:0],
                       has_par: 1'b1, par: r_node};
        node_raddr = r_par;
        fr_we      = 1'b0;
        fr_waddr   = push_pos;
        fr_wdata   = r_nc[gmss_pkg::NODE_AW-1:0];
        fr_raddr   = pop_pos;
        unique case (i_cmd.op)
            gmss_pkg::CMD_CLR: vis_we = 1'b1;
            gmss_pkg::CMD_SEED: begin
                node_we    = 1'b1;
                node_waddr = '0;
                node_wdata = '{row: r_start_row, col: r_start_col, has_par: 1'b0, par: '0};
                fr_we      = 1'b1;
                fr_waddr   = '0;
                fr_wdata   = '0;
            end
            gmss_pkg::CMD_WRITE:   cell_we = 1'b1;
            gmss_pkg::CMD_NODE_RD: node_raddr = fr_rdata;
            gmss_pkg::CMD_HERE_RD: begin
                cell_raddr = {node_rdata.row, node_rdata.col};
                vis_raddr  = {node_rdata.row, node_rdata.col};
            end
            gmss_pkg::CMD_BT_STEP: begin
                cell_we    = 1'b1;
                cell_waddr = {node_rdata.row, node_rdata.col};
                cell_wdata = gmss_pkg::CELL_PATH;
                node_raddr = node_rdata.par;
            end
            gmss_pkg::CMD_EXPAND: begin
                vis_we     = 1'b1;
                vis_waddr  = {r_r, r_c};
                vis_wdata  = 1'b1;
                cell_we    = (r_here == gmss_pkg::CELL_OPEN);
                cell_waddr = {r_r, r_c};
                cell_wdata = gmss_pkg::CELL_VISITED;
            end
            gmss_pkg::CMD_NB_RD:   cell_raddr = nb_addr;
            default: begin
            end
        endcase
        if (i_cmd.nb_chk && nb_take && !full) begin
            node_we = 1'b1;
            fr_we   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows    <= gmss_pkg::MAX_ROWS;
            r_num_cols    <= gmss_pkg::MAX_COLS;
            r_start_row   <= '0;
            r_start_col   <= '0;
            r_depth_first <= 1'b0;
            r_clr         <= '0;
            r_head        <= '0;
            r_cnt         <= '0;
            r_nc          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gmss_pkg::CFG_NUM_ROWS:    r_num_rows    <= i_cfg_data;
                    gmss_pkg::CFG_NUM_COLS:    r_num_cols    <= i_cfg_data;
                    gmss_pkg::CFG_START_ROW:   r_start_row   <= i_cfg_data[gmss_pkg::ROW_W-1:0];
                    gmss_pkg::CFG_START_COL:   r_start_col   <= i_cfg_data[gmss_pkg::COL_W-1:0];
                    gmss_pkg::CFG_DEPTH_FIRST: r_depth_first <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == gmss_pkg::CMD_CLR) r_clr <= r_clr + gmss_pkg::CELL_AW'(1);
            if (i_cmd.op == gmss_pkg::CMD_SEED) begin
                r_head <= '0;
                r_cnt  <= gmss_pkg::CNT_W'(1);
                r_nc   <= gmss_pkg::CNT_W'(1);
            end
            if (i_cmd.op == gmss_pkg::CMD_POP) begin
                r_cnt <= r_cnt - gmss_pkg::CNT_W'(1);
                if (!r_depth_first) r_head <= r_head + gmss_pkg::NODE_AW'(1);
            end
            if (i_cmd.nb_chk && nb_take && !full) begin
                r_cnt <= r_cnt + gmss_pkg::CNT_W'(1);
                r_nc  <= r_nc + gmss_pkg::CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            gmss_pkg::CMD_LATCH: begin
                r_req_row  <= i_in_data.row;
                r_req_col  <= i_in_data.col;
                r_req_code <= i_in_data.cell_code;
            end
            gmss_pkg::CMD_WRITE: begin
                r_res.out_row   <= r_req_row;
                r_res.out_col   <= r_req_col;
                r_res.read_code <= gmss_pkg::CELL_WALL;
            end
            gmss_pkg::CMD_READ_DONE: begin
                r_res.out_row   <= r_req_row;
                r_res.out_col   <= r_req_col;
                r_res.read_code <= cell_rdata;
            end
            gmss_pkg::CMD_SEED: begin
                r_res.out_row   <= r_start_row;
                r_res.out_col   <= r_start_col;
                r_res.read_code <= gmss_pkg::CELL_WALL;
            end
            gmss_pkg::CMD_EMPTY: begin
                r_res.out_row   <= '0;
                r_res.out_col   <= '0;
                r_res.read_code <= gmss_pkg::CELL_WALL;
            end
            gmss_pkg::CMD_NODE_RD: r_node <= fr_rdata;
            gmss_pkg::CMD_HERE_RD: begin
                r_r           <= node_rdata.row;
                r_c           <= node_rdata.col;
                r_has_par     <= node_rdata.has_par;
                r_par         <= node_rdata.par;
                r_res.out_row <= node_rdata.row;
                r_res.out_col <= node_rdata.col;
            end
            gmss_pkg::CMD_DECIDE: begin
                r_here          <= cell_rdata;
                r_res.read_code <= cell_rdata;
                r_guard         <= '0;
            end
            gmss_pkg::CMD_BT_STEP: r_guard <= r_guard + gmss_pkg::CNT_W'(1);
            gmss_pkg::CMD_EXPAND: begin
                r_dir  <= gmss_pkg::DIR_WEST;
                r_over <= 1'b0;
            end
            gmss_pkg::CMD_NB_NEXT: begin
                r_dir <= r_dir + 2'd1;
                if (i_cmd.nb_chk && nb_take && full) r_over <= 1'b1;
            end
            default: begin
            end
        endcase
        if (i_cmd.set_st) begin
            // overflow on the last neighbor lands in the same cycle
            if (i_cmd.nb_chk && (r_over || (nb_take && full))) begin
                r_res.status <= gmss_pkg::ST_OVERFLOW;
            end else begin
                r_res.status <= i_cmd.st;
            end
        end
        if (i_cmd.load) r_out <= r_res;
    end

    gmss_ram #(.WIDTH(gmss_pkg::CODE_W), .DEPTH(gmss_pkg::CELL_DEPTH)) u_cells (
        .i_clk(i_clk), .i_we(cell_we), .i_waddr(cell_waddr), .i_wdata(cell_wdata),
        .i_raddr(cell_raddr), .o_rdata(cell_rdata)
    );

    gmss_ram #(.WIDTH(1), .DEPTH(gmss_pkg::CELL_DEPTH)) u_visited (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_raddr(vis_raddr), .o_rdata(vis_rdata)
    );

    gmss_ram #(.WIDTH($bits(gmss_pkg::t_node)), .DEPTH(gmss_pkg::NODE_DEPTH)) u_nodes (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    gmss_ram #(.WIDTH(gmss_pkg::NODE_AW), .DEPTH(gmss_pkg::NODE_DEPTH)) u_frontier (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(fr_wdata),
        .i_raddr(fr_raddr), .o_rdata(fr_rdata)
    );

    always_comb begin
        o_stat          = '0;
        o_stat.req      = i_in_data.req_type;
        o_stat.fr_empty = (r_cnt == '0);
        o_stat.here_end = (cell_rdata == gmss_pkg::CELL_END);
        o_stat.here_vis = vis_rdata;
        o_stat.has_par  = r_has_par;
        o_stat.bt_go    = node_rdata.has_par && (r_guard < DEPTH_C);
        o_stat.nb_inb   = nb_inb;
        o_stat.dir_last = (r_dir == gmss_pkg::DIR_NORTH);
        o_stat.clr_last = (r_clr == '1);
        o_stat.over     = r_over;
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C) else $error("frontier count beyond depth");
    a_nodes_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nc >= r_cnt) else $error("frontier holds more entries than nodes");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || !i_out_stall)) else $error("result overwritten");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_out_valid) else $error("loaded result not shown");

endmodule

/* tb/sv/grid_maze_search_step_unit_tb.sv */
// Self-checking testbench for grid_maze_search_step_unit: random and directed
// requests, a cycle-free predictor of the search and a result scoreboard.
// Depends on gmss_pkg and the RTL top level only.
`timescale 1ns / 100ps

module grid_maze_search_step_unit_tb;

    localparam int GRID_CELLS = 64 * 64;
    localparam int WDOG_LIMIT = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    gmss_pkg::t_in_beat   i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    gmss_pkg::t_out_beat  o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [gmss_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [gmss_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    grid_maze_search_step_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // search state mirror
    logic [2:0] grid [GRID_CELLS];
    bit         seen [GRID_CELLS];
    bit         written [GRID_CELLS];
    int         nd_row [gmss_pkg::NODE_DEPTH];
    int         nd_col [gmss_pkg::NODE_DEPTH];
    bit         nd_has_par [gmss_pkg::NODE_DEPTH];
    int         nd_par [gmss_pkg::NODE_DEPTH];
    int         frontier [gmss_pkg::NODE_DEPTH];
    int         fr_cnt = 0, fr_head = 0, n_cnt = 0;
    int         m_rows = 64, m_cols = 64, m_srow = 0, m_scol = 0, m_dfs = 0;

    gmss_pkg::t_in_beat   pend_q [$];
    gmss_pkg::t_out_beat  expect_q [$];
    int         n_errors = 0;
    int         n_results = 0;
    int         idle_cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit push_node(int r, int c, bit has_par, int par);
        if (n_cnt >= gmss_pkg::NODE_DEPTH || fr_cnt >= gmss_pkg::NODE_DEPTH) return 1'b0;
        nd_row[n_cnt] = r & 63;
        nd_col[n_cnt] = c & 63;
        nd_has_par[n_cnt] = has_par;
        nd_par[n_cnt] = par;
        frontier[(fr_head + fr_cnt) % gmss_pkg::NODE_DEPTH] = n_cnt;
        n_cnt++;
        fr_cnt++;
        return 1'b1;
    endfunction

    function automatic gmss_pkg::t_out_beat predict_search(gmss_pkg::t_in_beat b);
        gmss_pkg::t_out_beat o;
        int dr [4] = '{0, 1, 0, -1};
        int dc [4] = '{-1, 0, 1, 0};
        int idx, node, r, c, nr, nc, er, ec, p, guard;
        logic [2:0] here, ch;
        bit has, over;
        o = '0;
        idx = b.row * 64 + b.col;
        case (b.req_type)
            gmss_pkg::REQ_WRITE: begin
                grid[idx] = b.cell_code;
                o.out_row = b.row;
                o.out_col = b.col;
            end
            gmss_pkg::REQ_READ: begin
                o.out_row = b.row;
                o.out_col = b.col;
                o.read_code = grid[idx];
            end
            gmss_pkg::REQ_RESTART: begin
                foreach (seen[i]) seen[i] = 1'b0;
                fr_cnt = 0;
                fr_head = 0;
                n_cnt = 0;
                void'(push_node(m_srow, m_scol, 1'b0, 0));
                o.out_row = 6'(m_srow);
                o.out_col = 6'(m_scol);
            end
            default: begin
                if (fr_cnt == 0) begin
                    o.status = gmss_pkg::ST_EMPTY;
                end else begin
                    if (m_dfs != 0) begin
                        node = frontier[(fr_head + fr_cnt - 1) % gmss_pkg::NODE_DEPTH];
                    end else begin
                        node = frontier[fr_head];
                        fr_head = (fr_head + 1) % gmss_pkg::NODE_DEPTH;
                    end
                    fr_cnt--;
                    r = nd_row[node];
                    c = nd_col[node];
                    here = grid[r * 64 + c];
                    o.out_row = 6'(r);
                    o.out_col = 6'(c);
                    o.read_code = here;
                    if (here == gmss_pkg::CELL_END) begin
                        // walk back from the parent; the root stays unmarked
                        has = nd_has_par[node];
                        p = nd_par[node];
                        guard = 0;
                        while (has && nd_has_par[p] && guard < gmss_pkg::NODE_DEPTH) begin
                            grid[nd_row[p] * 64 + nd_col[p]] = gmss_pkg::CELL_PATH;
                            p = nd_par[p];
                            guard++;
                        end
                        o.status = gmss_pkg::ST_SOLVED;
                    end else if (seen[r * 64 + c]) begin
                        o.status = gmss_pkg::ST_SKIPPED;
                    end else begin
                        er = (m_rows < 64) ? m_rows : 64;
                        ec = (m_cols < 64) ? m_cols : 64;
                        over = 1'b0;
                        seen[r * 64 + c] = 1'b1;
                        if (here == gmss_pkg::CELL_OPEN) grid[r * 64 + c] = gmss_pkg::CELL_VISITED;
                        for (int d = 0; d < 4; d++) begin
                            nr = r + dr[d];
                            nc = c + dc[d];
                            if (nr < 0 || nc < 0 || nr >= er || nc >= ec) continue;
                            ch = grid[nr * 64 + nc];
                            if ((ch == gmss_pkg::CELL_OPEN || ch == gmss_pkg::CELL_END)
                                && !seen[nr * 64 + nc])
                                if (!push_node(nr, nc, 1'b1, node)) over = 1'b1;
                        end
                        o.status = over ? gmss_pkg::ST_OVERFLOW : gmss_pkg::ST_EXPANDED;
                    end
                end
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        n_errors++;
        $display("result %0d: %s got %0d expected %0d", n_results, field, got, want);
    endtask

    // driver: hold a beat until taken, then idle a random gap
    int in_gap = 0;
    always @(posedge i_clk) begin
        bit offering;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expect_q.insert(expect_q.size(), predict_search(i_in_data));
                offering = 1'b0;
            end
            if (!offering) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pend_q.size() > 0) begin
                    i_in_data <= pend_q.pop_front();
                    offering = 1'b1;
                    in_gap = pick_gap();
                end
            end
            i_in_valid <= offering;
        end
    end

    // monitor: check each result beat and stall at random
    int  out_gap = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;
    always @(posedge i_clk) begin
        gmss_pkg::t_out_beat want;
        bit stall;
        if (o_out_valid && !i_out_stall) begin
            if (expect_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = expect_q.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", int'(o_out_data.status), int'(want.status));
                if (o_out_data.out_row !== want.out_row)
                    report_mismatch("out_row", int'(o_out_data.out_row), int'(want.out_row));
                if (o_out_data.out_col !== want.out_col)
                    report_mismatch("out_col", int'(o_out_data.out_col), int'(want.out_col));
                if (o_out_data.read_code !== want.read_code)
                    report_mismatch("read_code", int'(o_out_data.read_code),
                                    int'(want.read_code));
            end
            n_results++;
        end
        // one long hold-off so the input side backs up
        if (!held_once && n_results == 150) begin
            held_once = 1'b1;
            hold_left = 500;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall = 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            stall = 1'b1;
        end else begin
            out_gap = pick_gap();
            stall = 1'b0;
        end
        i_out_stall <= stall;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic gmss_pkg::t_in_beat mk(logic [1:0] req, int r, int c, int code);
        gmss_pkg::t_in_beat b;
        b.req_type = req;
        b.row = 6'(r);
        b.col = 6'(c);
        b.cell_code = 3'(code);
        if (req == gmss_pkg::REQ_WRITE) written[r * 64 + c] = 1'b1;
        return b;
    endfunction

    function automatic int rand_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 68) return int'(gmss_pkg::CELL_OPEN);
        if (r < 88) return int'(gmss_pkg::CELL_WALL);
        if (r < 93) return int'(gmss_pkg::CELL_END);
        return $urandom_range(3, 7);
    endfunction

    task automatic set_reg(logic [gmss_pkg::CFG_IDX_W-1:0] idx, int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[gmss_pkg::CFG_DATA_W-1:0];
        case (idx)
            gmss_pkg::CFG_NUM_ROWS:  m_rows = v & 127;
            gmss_pkg::CFG_NUM_COLS:  m_cols = v & 127;
            gmss_pkg::CFG_START_ROW: m_srow = v & 63;
            gmss_pkg::CFG_START_COL: m_scol = v & 63;
            default:                 m_dfs = v & 1;
        endcase
    endtask

    task automatic configure(int rows, int cols, int srow, int scol, int dfs);
        set_reg(gmss_pkg::CFG_NUM_ROWS, rows);
        set_reg(gmss_pkg::CFG_NUM_COLS, cols);
        set_reg(gmss_pkg::CFG_START_ROW, srow);
        set_reg(gmss_pkg::CFG_START_COL, scol);
        set_reg(gmss_pkg::CFG_DEPTH_FIRST, dfs);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || i_in_valid || expect_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_item(gmss_pkg::t_in_beat b);
        pend_q.insert(pend_q.size(), b);
    endtask

    // fill the grid in use and the start cell
    task automatic fill_grid(bit all_open);
        int er, ec;
        er = (m_rows < 64) ? m_rows : 64;
        ec = (m_cols < 64) ? m_cols : 64;
        for (int r = 0; r < er; r++)
            for (int c = 0; c < ec; c++)
                add_item(mk(gmss_pkg::REQ_WRITE, r, c,
                            all_open ? int'(gmss_pkg::CELL_OPEN) : rand_code()));
        add_item(mk(gmss_pkg::REQ_WRITE, m_srow, m_scol,
                    all_open ? int'(gmss_pkg::CELL_OPEN) : rand_code()));
    endtask

    initial begin
        int rows, cols, srow, scol, kind, er, ec, r, c, sel;
        foreach (grid[i]) grid[i] = gmss_pkg::CELL_WALL;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 3x3 maze, wall in the middle, end in the far corner
        configure(3, 3, 0, 0, 0);
        add_item(mk(gmss_pkg::REQ_STEP, 5, 9, 1));
        for (int i = 0; i < 9; i++)
            add_item(mk(gmss_pkg::REQ_WRITE, i / 3, i % 3,
                        (i == 4) ? int'(gmss_pkg::CELL_WALL) :
                        (i == 8) ? int'(gmss_pkg::CELL_END) : int'(gmss_pkg::CELL_OPEN)));
        add_item(mk(gmss_pkg::REQ_WRITE, 63, 63, 6));
        add_item(mk(gmss_pkg::REQ_READ, 63, 63, 0));
        add_item(mk(gmss_pkg::REQ_WRITE, 0, 63, 7));
        add_item(mk(gmss_pkg::REQ_READ, 0, 63, 5));
        add_item(mk(gmss_pkg::REQ_RESTART, 0, 0, 0));
        for (int i = 0; i < 8; i++) add_item(mk(gmss_pkg::REQ_STEP, 0, 0, 0));
        add_item(mk(gmss_pkg::REQ_READ, 1, 0, 0));
        drain();

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                rows = ($urandom_range(0, 1) != 0) ? 64 : 127;
                cols = $urandom_range(1, 2);
            end else if (kind == 1) begin
                rows = $urandom_range(1, 2);
                cols = ($urandom_range(0, 1) != 0) ? 64 : 100;
            end else begin
                rows = $urandom_range(1, 8);
                cols = $urandom_range(1, 8);
            end
            er = (rows < 64) ? rows : 64;
            ec = (cols < 64) ? cols : 64;
            if ($urandom_range(0, 4) == 0) begin
                srow = $urandom_range(0, 63);
                scol = $urandom_range(0, 63);
            end else begin
                srow = $urandom_range(0, er - 1);
                scol = $urandom_range(0, ec - 1);
            end
            configure(rows, cols, srow, scol, $urandom_range(0, 1));
            fill_grid(1'b0);
            // sometimes keep the old search going under the new setting
            if (ph == 0 || $urandom_range(0, 4) != 0)
                add_item(mk(gmss_pkg::REQ_RESTART, $urandom_range(0, 63),
                            $urandom_range(0, 63), $urandom_range(0, 7)));
            for (int i = 0; i < 110; i++) begin
                sel = $urandom_range(0, 99);
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
                if (sel < 64) begin
                    add_item(mk(gmss_pkg::REQ_STEP, r, c, $urandom_range(0, 7)));
                end else if (sel < 78) begin
                    if ($urandom_range(0, 1) != 0) begin
                        r = $urandom_range(0, er - 1);
                        c = $urandom_range(0, ec - 1);
                    end
                    add_item(mk(gmss_pkg::REQ_WRITE, r, c, $urandom_range(0, 7)));
                end else if (sel < 97) begin
                    if (!written[r * 64 + c]) begin
                        r = $urandom_range(0, er - 1);
                        c = $urandom_range(0, ec - 1);
                    end
                    add_item(mk(gmss_pkg::REQ_READ, r, c, $urandom_range(0, 7)));
                end else begin
                    add_item(mk(gmss_pkg::REQ_RESTART, r, c, $urandom_range(0, 7)));
                end
            end
            drain();
        end

        // open 16x16 grid, breadth first, end mid-grid for a long backtrace
        configure(16, 16, 0, 0, 0);
        fill_grid(1'b1);
        add_item(mk(gmss_pkg::REQ_WRITE, 6, 6, int'(gmss_pkg::CELL_END)));
        add_item(mk(gmss_pkg::REQ_RESTART, 0, 0, 0));
        for (int i = 0; i < 320; i++) add_item(mk(gmss_pkg::REQ_STEP, 0, 0, 0));
        drain();

        if (n_errors == 0 && expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
